// ----- design/env_comp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package env_comp_pkg;

    localparam int RAW_T_W    = 20;
    localparam int RAW_P_W    = 20;
    localparam int RAW_H_W    = 16;
    localparam int FINE_W     = 32;
    localparam int CENTI_W    = 24;
    localparam int PRESS_W    = 32;
    localparam int HUM_W      = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_A   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HUM_B   = 3'd5;

    // pipeline depths, counted in register stages
    localparam int TEMP_LAT   = 3;
    localparam int TC_LAT     = 4;
    localparam int DIV_STEPS  = 64;
    localparam int PRESS_LAT  = 11 + DIV_STEPS;
    localparam int HUM_LAT    = 10;
    localparam int PIPE_LAT   = TEMP_LAT + PRESS_LAT;
    localparam int HUM_DLY    = PRESS_LAT - HUM_LAT;
    localparam int TC_DLY     = PIPE_LAT - TC_LAT;

    localparam logic [31:0] HUM_MAX = 32'd419430400;

    typedef struct packed {
        logic [47:0] temp;
        logic [47:0] press_a;
        logic [47:0] press_b;
        logic [47:0] press_c;
        logic [31:0] hum_a;
        logic [31:0] hum_b;
    } calib_t;

endpackage

`default_nettype wire

// ----- design/env_comp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface env_comp_in_if;
    logic                               valid;
    logic                               ready;
    logic [env_comp_pkg::RAW_T_W-1:0]   raw_temperature;
    logic [env_comp_pkg::RAW_P_W-1:0]   raw_pressure;
    logic [env_comp_pkg::RAW_H_W-1:0]   raw_humidity;

    modport source (output valid, output raw_temperature, output raw_pressure,
                    output raw_humidity, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure,
                    input raw_humidity, output ready);
endinterface

`default_nettype wire

// ----- design/env_comp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface env_comp_out_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [env_comp_pkg::FINE_W-1:0]  fine_temperature;
    logic signed [env_comp_pkg::CENTI_W-1:0] temperature_centi;
    logic [env_comp_pkg::PRESS_W-1:0]        pressure_q24_8;
    logic [env_comp_pkg::HUM_W-1:0]          humidity_q22_10;
    logic                                    pressure_divisor_zero;

    modport source (output valid, output fine_temperature, output temperature_centi,
                    output pressure_q24_8, output humidity_q22_10,
                    output pressure_divisor_zero, input ready);
    modport sink   (input valid, input fine_temperature, input temperature_centi,
                    input pressure_q24_8, input humidity_q22_10,
                    input pressure_divisor_zero, output ready);
endinterface

`default_nettype wire

// ----- design/env_comp_temp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module env_comp_temp (
    input  logic                 clk,
    input  logic                 en,
    input  env_comp_pkg::calib_t calib,
    input  logic [19:0]          raw_temperature,
    input  logic [19:0]          raw_pressure,
    input  logic [15:0]          raw_humidity,
    output logic signed [31:0]   fine,
    output logic [19:0]          raw_pressure_d,
    output logic [15:0]          raw_humidity_d,
    output logic signed [31:0]   fine_d,
    output logic [23:0]          centi
);

    logic [15:0]        t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;

    logic signed [17:0] da;
    logic signed [16:0] db;
    logic signed [33:0] pa_full;
    logic signed [33:0] dd_full;
    logic signed [35:0] bt_full;
    logic [31:0]        tc_sum;

    logic [31:0]        pa_reg, dd_reg;
    logic signed [31:0] a_reg, b_reg, a_next, b_next;
    logic signed [31:0] tf_reg;
    logic [19:0]        rp1_reg, rp2_reg, rp3_reg;
    logic [15:0]        rh1_reg, rh2_reg, rh3_reg;
    logic signed [31:0] tf4_reg;
    logic [23:0]        tc_reg;

    assign t1 = calib.temp[15:0];
    assign t2 = $signed(calib.temp[31:16]);
    assign t3 = $signed(calib.temp[47:32]);

    always_comb
    begin
        da      = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
        db      = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
        pa_full = da * t2;
        dd_full = db * db;
        a_next  = $signed(pa_reg) >>> 11;
        bt_full = $signed(dd_reg[31:12]) * t3;
        b_next  = $signed(bt_full[31:0]) >>> 14;
        tc_sum  = {tf_reg[29:0], 2'b00} + tf_reg + 32'd128;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= pa_full[31:0];
            dd_reg  <= dd_full[31:0];
            rp1_reg <= raw_pressure;
            rh1_reg <= raw_humidity;
            a_reg   <= a_next;
            b_reg   <= b_next;
            rp2_reg <= rp1_reg;
            rh2_reg <= rh1_reg;
            tf_reg  <= a_reg + b_reg;
            rp3_reg <= rp2_reg;
            rh3_reg <= rh2_reg;
            tf4_reg <= tf_reg;
            tc_reg  <= tc_sum[31:8];
        end
    end

    assign fine           = tf_reg;
    assign raw_pressure_d = rp3_reg;
    assign raw_humidity_d = rh3_reg;
    assign fine_d         = tf4_reg;
    assign centi          = tc_reg;

endmodule

`default_nettype wire

// ----- design/env_comp_hum.sv -----
`timescale 1ns / 1ps
`default_nettype none

module env_comp_hum (
    input  logic                 clk,
    input  logic                 en,
    input  env_comp_pkg::calib_t calib,
    input  logic signed [31:0]   fine,
    input  logic [15:0]          raw_humidity,
    output logic [16:0]          humidity
);

    logic [7:0]         h1, h3;
    logic signed [15:0] h2;
    logic signed [11:0] h4, h5;
    logic signed [7:0]  h6;

    logic [31:0]        h4s, x_sum, y2_next, zz, y_sum, r, rc;
    logic signed [43:0] m5_full;
    logic signed [39:0] m6_full;
    logic signed [40:0] m3_full;
    logic signed [53:0] yy_full;
    logic signed [47:0] z_full;
    logic signed [34:0] v_full;
    logic signed [33:0] ss_full;
    logic signed [33:0] w_full;

    logic [31:0]        v0_reg;
    logic [15:0]        ah0_reg, ah1_reg;
    logic [31:0]        m5_reg, m6_reg, m3_reg;
    logic signed [16:0] x2_reg, x3_reg, x4_reg, x5_reg;
    logic signed [21:0] y1_reg;
    logic [31:0]        y2_reg;
    logic [31:0]        yy_reg, z_reg;
    logic signed [17:0] y_reg;
    logic [31:0]        v6_reg, v7_reg, v8_reg;
    logic [31:0]        ss_reg, w_reg;
    logic [16:0]        hum_reg;

    assign h1 = calib.hum_a[7:0];
    assign h2 = $signed(calib.hum_a[23:8]);
    assign h3 = calib.hum_a[31:24];
    assign h4 = $signed(calib.hum_b[11:0]);
    assign h5 = $signed(calib.hum_b[23:12]);
    assign h6 = $signed(calib.hum_b[31:24]);

    always_comb
    begin
        m5_full = $signed(v0_reg) * h5;
        m6_full = $signed(v0_reg) * h6;
        m3_full = $signed(v0_reg) * $signed({1'b0, h3});
        h4s     = {{20{h4[11]}}, h4};
        x_sum   = {2'b00, ah1_reg, 14'b0} - (h4s << 20) - m5_reg + 32'd16384;
        y2_next = {{11{m3_reg[31]}}, m3_reg[31:11]} + 32'd32768;
        yy_full = y1_reg * $signed(y2_reg);
        zz      = {{10{yy_reg[31]}}, yy_reg[31:10]} + 32'd2097152;
        z_full  = $signed(zz) * h2;
        y_sum   = z_reg + 32'd8192;
        v_full  = x5_reg * y_reg;
        ss_full = $signed(v6_reg[31:15]) * $signed(v6_reg[31:15]);
        w_full  = $signed(ss_reg[31:7]) * $signed({1'b0, h1});
        r       = v8_reg - {{4{w_reg[31]}}, w_reg[31:4]};
        if (r[31])
            rc = '0;
        else if (r > env_comp_pkg::HUM_MAX)
            rc = env_comp_pkg::HUM_MAX;
        else
            rc = r;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v0_reg  <= fine - 32'sd76800;
            ah0_reg <= raw_humidity;
            m5_reg  <= m5_full[31:0];
            m6_reg  <= m6_full[31:0];
            m3_reg  <= m3_full[31:0];
            ah1_reg <= ah0_reg;
            x2_reg  <= $signed(x_sum[31:15]);
            y1_reg  <= $signed(m6_reg[31:10]);
            y2_reg  <= y2_next;
            yy_reg  <= yy_full[31:0];
            x3_reg  <= x2_reg;
            z_reg   <= z_full[31:0];
            x4_reg  <= x3_reg;
            y_reg   <= $signed(y_sum[31:14]);
            x5_reg  <= x4_reg;
            v6_reg  <= v_full[31:0];
            ss_reg  <= ss_full[31:0];
            v7_reg  <= v6_reg;
            w_reg   <= w_full[31:0];
            v8_reg  <= v7_reg;
            hum_reg <= rc[28:12];
        end
    end

    assign humidity = hum_reg;

endmodule

`default_nettype wire

// ----- design/env_comp_press.sv -----
`timescale 1ns / 1ps
`default_nettype none

module env_comp_press (
    input  logic                 clk,
    input  logic                 en,
    input  env_comp_pkg::calib_t calib,
    input  logic signed [31:0]   fine,
    input  logic [19:0]          raw_pressure,
    output logic [31:0]          pressure,
    output logic                 div_zero
);

    typedef struct packed {
        logic [63:0] quo;
        logic [30:0] rem;
        logic [30:0] md;
        logic        qneg;
        logic        dz;
    } div_stage_t;

    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

    logic signed [32:0] v1;
    logic signed [65:0] sq_full;
    logic signed [48:0] m5_full, m2_full;
    logic signed [79:0] v2a_full, t3_full;
    logic [63:0]        m5x, m2x, p4x, p7x, v2_next, v1b_next;
    logic [63:0]        x_sum, nd;
    logic [79:0]        pd_full;
    logic [75:0]        num_full;
    logic [63:0]        mn;
    logic [30:0]        md;
    logic [63:0]        p_next, ps_next, s_next, r_next, sum;
    logic signed [79:0] m9_full, m8_full;
    logic [31:0]        pq_next;

    logic [63:0]        sq_reg, v2a_reg, t3_reg, v2_reg, v1b_reg, num_reg;
    logic [48:0]        m5_reg, m2_reg, m5d_reg, m2d_reg;
    logic [20:0]        np1_reg, np2_reg, np3_reg;
    logic [30:0]        dvs_reg;
    div_stage_t         div_reg [env_comp_pkg::DIV_STEPS+1];
    logic [63:0]        p0_reg, p1_reg, p2_reg, p3_reg;
    logic [63:0]        ps_reg, m9_reg, m8_reg;
    logic [63:0]        ll_reg, v2q2_reg, v2q3_reg, s_reg, r_reg;
    logic [31:0]        lh_reg, hl_reg;
    logic [5:0]         dz_reg;
    logic [31:0]        pq_reg;

    assign p1 = calib.press_a[15:0];
    assign p2 = $signed(calib.press_a[31:16]);
    assign p3 = $signed(calib.press_a[47:32]);
    assign p4 = $signed(calib.press_b[15:0]);
    assign p5 = $signed(calib.press_b[31:16]);
    assign p6 = $signed(calib.press_b[47:32]);
    assign p7 = $signed(calib.press_c[15:0]);
    assign p8 = $signed(calib.press_c[31:16]);
    assign p9 = $signed(calib.press_c[47:32]);

    always_comb
    begin
        v1       = $signed({fine[31], fine}) - 33'sd128000;
        sq_full  = v1 * v1;
        m5_full  = v1 * p5;
        m2_full  = v1 * p2;
        v2a_full = $signed(sq_reg) * p6;
        t3_full  = $signed(sq_reg) * p3;
        m5x      = {{15{m5d_reg[48]}}, m5d_reg};
        m2x      = {{15{m2d_reg[48]}}, m2d_reg};
        p4x      = {{48{p4[15]}}, p4};
        p7x      = {{48{p7[15]}}, p7};
        v2_next  = v2a_reg + (m5x << 17) + (p4x << 35);
        v1b_next = 64'($signed(t3_reg) >>> 8) + (m2x << 12);
        x_sum    = 64'h0000_8000_0000_0000 + v1b_reg;
        pd_full  = x_sum * p1;
        nd       = {12'b0, np3_reg, 31'b0} - v2_reg;
        num_full = nd * 12'd3125;
        mn       = num_reg[63] ? (64'd0 - num_reg) : num_reg;
        md       = dvs_reg[30] ? (31'd0 - dvs_reg) : dvs_reg;
    end

    // pressure multiply stages and entry of the restoring divider
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg  <= sq_full[63:0];
            m5_reg  <= m5_full;
            m2_reg  <= m2_full;
            np1_reg <= 21'd1048576 - {1'b0, raw_pressure};
            v2a_reg <= v2a_full[63:0];
            t3_reg  <= t3_full[63:0];
            m5d_reg <= m5_reg;
            m2d_reg <= m2_reg;
            np2_reg <= np1_reg;
            v2_reg  <= v2_next;
            v1b_reg <= v1b_next;
            np3_reg <= np2_reg;
            dvs_reg <= pd_full[63:33];
            num_reg <= num_full[63:0];
            div_reg[0].quo  <= mn;
            div_reg[0].rem  <= '0;
            div_reg[0].md   <= md;
            div_reg[0].qneg <= num_reg[63] ^ dvs_reg[30];
            div_reg[0].dz   <= (dvs_reg == '0);
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < env_comp_pkg::DIV_STEPS; i++)
    begin : g_div
        logic [31:0] trial;
        logic        ge;
        div_stage_t  nxt;

        always_comb
        begin
            trial     = {div_reg[i].rem, div_reg[i].quo[63]};
            ge        = (trial >= {1'b0, div_reg[i].md});
            nxt       = div_reg[i];
            nxt.rem   = ge ? 31'(trial - {1'b0, div_reg[i].md}) : trial[30:0];
            nxt.quo   = {div_reg[i].quo[62:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                div_reg[i+1] <= nxt;
        end
    end

    always_comb
    begin
        p_next  = div_reg[env_comp_pkg::DIV_STEPS].qneg ?
                  (64'd0 - div_reg[env_comp_pkg::DIV_STEPS].quo) :
                  div_reg[env_comp_pkg::DIV_STEPS].quo;
        ps_next = 64'($signed(p0_reg) >>> 13);
        m9_full = $signed(ps_next) * p9;
        m8_full = $signed(p0_reg) * p8;
        s_next  = ll_reg + {lh_reg + hl_reg, 32'b0};
        sum     = p3_reg + 64'($signed(s_reg) >>> 25) + v2q3_reg;
        r_next  = 64'($signed(sum) >>> 8) + (p7x << 4);
        priority if (dz_reg[4])
            pq_next = '0;
        else if (r_reg[63])
            pq_next = '0;
        else if (r_reg[63:32] != '0)
            pq_next = '1;
        else
            pq_next = r_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= p_next;
            dz_reg   <= {dz_reg[4:0], div_reg[env_comp_pkg::DIV_STEPS].dz};
            ps_reg   <= ps_next;
            m9_reg   <= m9_full[63:0];
            m8_reg   <= m8_full[63:0];
            p1_reg   <= p0_reg;
            ll_reg   <= m9_reg[31:0] * ps_reg[31:0];
            lh_reg   <= m9_reg[31:0] * ps_reg[63:32];
            hl_reg   <= m9_reg[63:32] * ps_reg[31:0];
            v2q2_reg <= 64'($signed(m8_reg) >>> 19);
            p2_reg   <= p1_reg;
            s_reg    <= s_next;
            v2q3_reg <= v2q2_reg;
            p3_reg   <= p2_reg;
            r_reg    <= r_next;
            pq_reg   <= pq_next;
        end
    end

    assign pressure = pq_reg;
    assign div_zero = dz_reg[5];

endmodule

`default_nettype wire

// ----- design/env_sensor_compensation_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// sensor    in   valid/ready    raw_temperature, raw_pressure, raw_humidity
// result    out  valid/ready    fine_temperature, temperature_centi, pressure_q24_8,
//                               humidity_q22_10, pressure_divisor_zero
// cfg       in   cfg_we         cfg_index, cfg_data (calibration words)
//
// One transaction per cycle in and out while the result is taken; the longest path runs through
// the 64-stage pressure divider (one quotient bit per stage) plus the multiply stages.
// The whole pipeline advances together; it holds when the output stage is full
// and not taken, so sensor.ready drops only while result is stalled.
// Reset clears the calibration words and the valid bits; no clearing pass.

module env_sensor_compensation_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    env_comp_in_if.sink                          sensor,
    env_comp_out_if.source                       result,
    input  logic                                 cfg_we,
    input  logic [env_comp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [env_comp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int PL = env_comp_pkg::PIPE_LAT;
    localparam int TD = env_comp_pkg::TC_DLY;
    localparam int HD = env_comp_pkg::HUM_DLY;

    env_comp_pkg::calib_t calib_reg;
    logic [PL-1:0]        vld_reg;
    logic                 en;

    logic signed [31:0]   fine, fine_d;
    logic [19:0]          rp_d;
    logic [15:0]          rh_d;
    logic [23:0]          centi;
    logic [16:0]          hum;
    logic [31:0]          press;
    logic                 dz;

    logic [55:0]          tfc_reg [TD];
    logic [16:0]          hum_reg [HD];

    assign en           = !vld_reg[PL-1] || result.ready;
    assign sensor.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            calib_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                env_comp_pkg::CFG_TEMP:    calib_reg.temp    <= cfg_data;
                env_comp_pkg::CFG_PRESS_A: calib_reg.press_a <= cfg_data;
                env_comp_pkg::CFG_PRESS_B: calib_reg.press_b <= cfg_data;
                env_comp_pkg::CFG_PRESS_C: calib_reg.press_c <= cfg_data;
                env_comp_pkg::CFG_HUM_A:   calib_reg.hum_a   <= cfg_data[31:0];
                env_comp_pkg::CFG_HUM_B:   calib_reg.hum_b   <= cfg_data[31:0];
                default:                   calib_reg         <= calib_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[PL-2:0], sensor.valid};
    end

    env_comp_temp u_temp (
        .clk             (clk),
        .en              (en),
        .calib           (calib_reg),
        .raw_temperature (sensor.raw_temperature),
        .raw_pressure    (sensor.raw_pressure),
        .raw_humidity    (sensor.raw_humidity),
        .fine            (fine),
        .raw_pressure_d  (rp_d),
        .raw_humidity_d  (rh_d),
        .fine_d          (fine_d),
        .centi           (centi)
    );

    env_comp_press u_press (
        .clk          (clk),
        .en           (en),
        .calib        (calib_reg),
        .fine         (fine),
        .raw_pressure (rp_d),
        .pressure     (press),
        .div_zero     (dz)
    );

    env_comp_hum u_hum (
        .clk          (clk),
        .en           (en),
        .calib        (calib_reg),
        .fine         (fine),
        .raw_humidity (rh_d),
        .humidity     (hum)
    );

    // align temperature and humidity with the pressure result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tfc_reg[0] <= {fine_d, centi};
            for (int i = 1; i < TD; i++)
                tfc_reg[i] <= tfc_reg[i-1];
            hum_reg[0] <= hum;
            for (int j = 1; j < HD; j++)
                hum_reg[j] <= hum_reg[j-1];
        end
    end

    assign result.valid                 = vld_reg[PL-1];
    assign result.fine_temperature      = $signed(tfc_reg[TD-1][55:24]);
    assign result.temperature_centi     = $signed(tfc_reg[TD-1][23:0]);
    assign result.pressure_q24_8        = press;
    assign result.humidity_q22_10       = hum_reg[HD-1];
    assign result.pressure_divisor_zero = dz;

endmodule

`default_nettype wire

// ----- design/env_comp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module env_comp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] fine_temperature,
    input logic [23:0] temperature_centi,
    input logic [31:0] pressure_q24_8,
    input logic [16:0] humidity_q22_10,
    input logic        pressure_divisor_zero
);

    logic [31:0] tc_sum;

    assign tc_sum = {fine_temperature[29:0], 2'b00} + fine_temperature + 32'd128;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pressure_q24_8)
            && $stable(fine_temperature) && $stable(humidity_q22_10))
        else $error("result changed while stalled");

    a_centi: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> temperature_centi == tc_sum[31:8])
        else $error("centi temperature does not follow fine temperature");

    a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> humidity_q22_10 <= 17'd102400)
        else $error("humidity above full scale");

    a_dz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pressure_divisor_zero |-> pressure_q24_8 == '0)
        else $error("pressure not forced to zero on zero divisor");

endmodule

bind env_sensor_compensation_top env_comp_checker u_chk (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .out_valid             (result.valid),
    .out_ready             (result.ready),
    .fine_temperature      (result.fine_temperature),
    .temperature_centi     (result.temperature_centi),
    .pressure_q24_8        (result.pressure_q24_8),
    .humidity_q22_10       (result.humidity_q22_10),
    .pressure_divisor_zero (result.pressure_divisor_zero)
);

`default_nettype wire
